### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the key matrix event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/kmeq_pkg.sv
// Shared constants, payload types, keymap ROM and helper functions of the key matrix event queue.
package kmeq_pkg;

    localparam int unsigned RING_DEPTH_DEF  = 16;
    localparam int unsigned MATRIX_ROWS_DEF = 5;
    localparam int unsigned MATRIX_COLS_DEF = 5;

    localparam int unsigned FRAME_W     = 50;
    localparam int unsigned FRAME_LIMIT = 64;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned WAIT_W      = 4;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 1;

    localparam int unsigned ROM_ROWS      = 5;
    localparam int unsigned ROM_COLS      = 5;
    localparam int unsigned SHIFT_KEY_ROW = 3;
    localparam int unsigned SHIFT_KEY_COL = 0;

    localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_PRESENT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_PRESENT = 1'd1;

    localparam logic [CODE_W-1:0] CODE_NOP    = 8'h00;
    localparam logic [CODE_W-1:0] CODE_SHIFT  = 8'h01;
    localparam logic [CODE_W-1:0] CASE_OFFSET = 8'h20;
    localparam logic [CODE_W-1:0] LOWER_A     = 8'h61;
    localparam logic [CODE_W-1:0] LOWER_Z     = 8'h7a;

    localparam logic [CODE_W-1:0] KEYMAP [2][ROM_ROWS][ROM_COLS] = '{
        '{
            '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35},
            '{8'h71, 8'h77, 8'h65, 8'h72, 8'h74},
            '{8'h61, 8'h73, 8'h64, 8'h66, 8'h67},
            '{CODE_SHIFT, 8'h7a, 8'h78, 8'h63, 8'h76},
            '{CODE_NOP, 8'h09, CODE_NOP, 8'h2c, 8'h20}
        },
        '{
            '{8'h36, 8'h37, 8'h38, 8'h39, 8'h30},
            '{8'h79, 8'h75, 8'h69, 8'h6f, 8'h70},
            '{8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h08},
            '{8'h62, 8'h6e, 8'h6d, CODE_NOP, 8'h0d},
            '{CODE_NOP, 8'h2e, CODE_NOP, 8'h23, CODE_NOP}
        }
    };

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] scan_frame;
    } in_word_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              key_valid;
        logic [WAIT_W-1:0] keys_waiting;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic left_present;
        logic right_present;
    } scan_ctrl_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } push_t;

    function automatic logic [CODE_W-1:0] rom_code(logic half, logic [2:0] row,
                                                   logic [2:0] col);
        logic [CODE_W-1:0] code;
        code = CODE_NOP;
        if (row < 3'(ROM_ROWS) && col < 3'(ROM_COLS)) begin
            code = KEYMAP[half][row][col];
        end
        return code;
    endfunction

    function automatic logic frame_bit(logic [FRAME_W-1:0] frame, int unsigned idx);
        logic value;
        if (idx >= FRAME_LIMIT) begin
            value = 1'b1;
        end else if (idx >= FRAME_W) begin
            value = 1'b0;
        end else begin
            value = frame[idx];
        end
        return value;
    endfunction

endpackage

### rtl/core/kmeq_ram.sv
// Generic single write port RAM with one registered read port.
module kmeq_ram #(
    parameter int unsigned WIDTH = kmeq_pkg::CODE_W,
    parameter int unsigned DEPTH = kmeq_pkg::RING_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### rtl/core/kmeq_scanner.sv
// Key walker: steps through one key per cycle, tracks row history and emits new key codes.
module kmeq_scanner #(
    parameter int unsigned MATRIX_ROWS = kmeq_pkg::MATRIX_ROWS_DEF,
    parameter int unsigned MATRIX_COLS = kmeq_pkg::MATRIX_COLS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  kmeq_pkg::scan_ctrl_t         ctrl,
    input  logic [kmeq_pkg::FRAME_W-1:0] frame,
    output kmeq_pkg::push_t              push,
    output logic                         done
);

    localparam int unsigned NUM_ROWS  = 2 * MATRIX_ROWS;
    localparam int unsigned NUM_KEYS  = NUM_ROWS * MATRIX_COLS;
    localparam int unsigned ROW_W     = $clog2(NUM_ROWS);
    localparam int unsigned COL_W     = (MATRIX_COLS > 1) ? $clog2(MATRIX_COLS) : 1;
    localparam int unsigned KEY_W     = $clog2(NUM_KEYS);
    localparam int unsigned SHIFT_IDX = kmeq_pkg::SHIFT_KEY_ROW * MATRIX_COLS +
                                        kmeq_pkg::SHIFT_KEY_COL;
    localparam bit          SHIFT_OK  = (kmeq_pkg::SHIFT_KEY_ROW < MATRIX_ROWS) &&
                                        (kmeq_pkg::SHIFT_KEY_COL < MATRIX_COLS);

    typedef enum logic [1:0] {
        SC_IDLE = 2'b01,
        SC_WALK = 2'b10
    } scan_state_t;

    scan_state_t                   state_reg;
    logic [kmeq_pkg::FRAME_W-1:0]  frame_sr_reg;
    logic [KEY_W-1:0]              key_reg;
    logic [ROW_W-1:0]              row_reg;
    logic [COL_W-1:0]              col_reg;
    logic [MATRIX_COLS-1:0]        now_reg;
    logic                          shift_reg;
    logic [MATRIX_COLS-1:0]        prev_rows_reg [NUM_ROWS];

    logic                          walk;
    logic                          half;
    logic [ROW_W-1:0]              row_in_half;
    logic                          present;
    logic                          cur;
    logic                          old;
    logic [kmeq_pkg::CODE_W-1:0]   raw_code;
    logic                          is_lower;
    logic [MATRIX_COLS-1:0]        now_full;
    logic                          last_col;
    logic                          last_key;

    assign walk        = (state_reg == SC_WALK);
    assign half        = (row_reg >= ROW_W'(MATRIX_ROWS));
    assign row_in_half = half ? (row_reg - ROW_W'(MATRIX_ROWS)) : row_reg;
    assign present     = half ? ctrl.right_present : ctrl.left_present;
    assign cur         = (32'(key_reg) >= kmeq_pkg::FRAME_LIMIT) ? 1'b1 : frame_sr_reg[0];
    assign old         = prev_rows_reg[row_reg][col_reg];
    assign raw_code    = kmeq_pkg::rom_code(half, 3'(row_in_half), 3'(col_reg));
    assign is_lower    = (raw_code >= kmeq_pkg::LOWER_A) && (raw_code <= kmeq_pkg::LOWER_Z);
    assign last_col    = (col_reg == COL_W'(MATRIX_COLS - 1));
    assign last_key    = (key_reg == KEY_W'(NUM_KEYS - 1));

    always_comb begin
        now_full          = now_reg;
        now_full[col_reg] = cur;
    end

    assign push.valid = walk && present && !cur && old &&
                        (raw_code != kmeq_pkg::CODE_NOP) && (raw_code != kmeq_pkg::CODE_SHIFT);
    assign push.code  = (shift_reg && is_lower) ? (raw_code - kmeq_pkg::CASE_OFFSET) : raw_code;
    assign done       = walk && last_key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            key_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            for (int i = 0; i < NUM_ROWS; i++) begin
                prev_rows_reg[i] <= '1;
            end
        end else begin
            case (state_reg)
                SC_IDLE: begin
                    if (ctrl.start) begin
                        frame_sr_reg <= frame;
                        shift_reg    <= SHIFT_OK && ctrl.left_present &&
                                        !kmeq_pkg::frame_bit(frame, SHIFT_IDX);
                        key_reg      <= '0;
                        row_reg      <= '0;
                        col_reg      <= '0;
                        now_reg      <= '0;
                        state_reg    <= SC_WALK;
                    end
                end
                SC_WALK: begin
                    frame_sr_reg <= frame_sr_reg >> 1;
                    key_reg      <= key_reg + 1'b1;
                    if (last_col) begin
                        if (present) begin
                            prev_rows_reg[row_reg] <= now_full;
                        end
                        now_reg <= '0;
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end else begin
                        now_reg <= now_full;
                        col_reg <= col_reg + 1'b1;
                    end
                    if (last_key) begin
                        state_reg <= SC_IDLE;
                    end
                end
                default: begin
                    state_reg <= SC_IDLE;
                end
            endcase
            if (ctrl.clear) begin
                for (int i = 0; i < NUM_ROWS; i++) begin
                    prev_rows_reg[i] <= '1;
                end
            end
        end
    end

endmodule

### rtl/core/key_matrix_event_queue_unit.sv
// Top level of the key matrix event queue: handshake, sequencer, key ring and result register.
// A scan word is handled by the key walker, which visits all 2*MATRIX_ROWS*MATRIX_COLS keys,
// one key per cycle, before the sequencer moves on to ST_FINISH.
// A read word of a non-empty ring takes one ring RAM read in ST_READ; other non-scan words skip it.
// One word is in work at a time; the result register lets the next word enter while it waits.
// Synchronous active-low reset releases all keys and empties the ring; ring contents stay undefined.
module key_matrix_event_queue_unit #(
    parameter int unsigned RING_DEPTH  = kmeq_pkg::RING_DEPTH_DEF,
    parameter int unsigned MATRIX_ROWS = kmeq_pkg::MATRIX_ROWS_DEF,
    parameter int unsigned MATRIX_COLS = kmeq_pkg::MATRIX_COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [kmeq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kmeq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  kmeq_pkg::in_word_t              s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output kmeq_pkg::out_word_t             m_payload
);

    localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
    localparam int unsigned HELD_W = PTR_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                       state_reg;
    logic                         left_reg;
    logic                         right_reg;
    logic [PTR_W-1:0]             head_reg;
    logic [PTR_W-1:0]             tail_reg;
    logic [kmeq_pkg::CODE_W-1:0]  res_code_reg;
    logic                         res_valid_reg;
    logic                         m_valid_reg;
    kmeq_pkg::out_word_t          m_payload_reg;

    logic                         accept;
    logic [PTR_W-1:0]             head_next;
    logic [PTR_W-1:0]             tail_next;
    logic                         ring_full;
    logic                         ring_empty;
    logic                         do_push;
    logic [HELD_W-1:0]            held;
    logic [kmeq_pkg::CODE_W-1:0]  ring_rdata;
    kmeq_pkg::scan_ctrl_t         scan_ctrl;
    kmeq_pkg::push_t              push;
    logic                         scan_done;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign head_next  = (head_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : (head_reg + 1'b1);
    assign tail_next  = (tail_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : (tail_reg + 1'b1);
    assign ring_full  = (head_next == tail_reg);
    assign ring_empty = (head_reg == tail_reg);
    assign do_push    = push.valid && !ring_full;
    assign held       = (head_reg >= tail_reg) ?
                        ({1'b0, head_reg} - {1'b0, tail_reg}) :
                        ({1'b0, head_reg} + HELD_W'(RING_DEPTH) - {1'b0, tail_reg});

    assign scan_ctrl.start         = accept && (s_payload.op == kmeq_pkg::OP_SCAN);
    assign scan_ctrl.clear         = accept && (s_payload.op == kmeq_pkg::OP_CLEAR);
    assign scan_ctrl.left_present  = left_reg;
    assign scan_ctrl.right_present = right_reg;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    kmeq_scanner #(
        .MATRIX_ROWS(MATRIX_ROWS),
        .MATRIX_COLS(MATRIX_COLS)
    ) u_scanner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (scan_ctrl),
        .frame   (s_payload.scan_frame),
        .push    (push),
        .done    (scan_done)
    );

    kmeq_ram #(
        .WIDTH(kmeq_pkg::CODE_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (do_push),
        .waddr (head_reg),
        .wdata (push.code),
        .raddr (tail_reg),
        .rdata (ring_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            left_reg    <= 1'b0;
            right_reg   <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    kmeq_pkg::CFG_LEFT_PRESENT:  left_reg  <= cfg_wdata[0];
                    kmeq_pkg::CFG_RIGHT_PRESENT: right_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (do_push) begin
                head_reg <= head_next;
            end
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_code_reg  <= kmeq_pkg::CODE_NOP;
                        res_valid_reg <= 1'b0;
                        case (s_payload.op)
                            kmeq_pkg::OP_SCAN: begin
                                state_reg <= ST_SCAN;
                            end
                            kmeq_pkg::OP_CLEAR: begin
                                head_reg  <= '0;
                                tail_reg  <= '0;
                                state_reg <= ST_FINISH;
                            end
                            kmeq_pkg::OP_READ: begin
                                state_reg <= ring_empty ? ST_FINISH : ST_READ;
                            end
                            default: begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_READ: begin
                    res_code_reg  <= ring_rdata;
                    res_valid_reg <= 1'b1;
                    tail_reg      <= tail_next;
                    state_reg     <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_payload_reg.key_code     <= res_code_reg;
                        m_payload_reg.key_valid    <= res_valid_reg;
                        m_payload_reg.keys_waiting <= kmeq_pkg::WAIT_W'(held);
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/kmeq_checker.sv
// Port-level assertions for the key matrix event queue and their binding to the top level.
`include "assert_macros.svh"

module kmeq_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input kmeq_pkg::out_word_t m_payload
);

    // A result that is not taken must hold still.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_payload), "result word changed while stalled")

    // Key codes are never zero, so the valid flag and a non-zero code go together.
    `ASSERT_CLK(a_code_flag, aclk, aresetn, m_valid |-> (m_payload.key_valid == (m_payload.key_code != kmeq_pkg::CODE_NOP)), "key_valid disagrees with key_code")

    // Every word keeps the block busy for at least the cycle after it is taken.
    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input ready right after a word was taken")

    // Reset leaves no result pending.
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind key_matrix_event_queue_unit kmeq_checker u_kmeq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

### tb/sv/key_matrix_event_queue_unit_tb.sv
// Self-checking testbench of the key matrix event queue: directed and random words with a scoreboard.
`timescale 1ns / 100ps

module key_matrix_event_queue_unit_tb;

    localparam int unsigned RING       = kmeq_pkg::RING_DEPTH_DEF;
    localparam int unsigned ROWS       = kmeq_pkg::MATRIX_ROWS_DEF;
    localparam int unsigned COLS       = kmeq_pkg::MATRIX_COLS_DEF;
    localparam int unsigned SHIFT_BIT  = kmeq_pkg::SHIFT_KEY_ROW * COLS + kmeq_pkg::SHIFT_KEY_COL;
    localparam int unsigned SETTLE     = 64;
    localparam int unsigned LONG_HOLD  = 400;
    localparam int unsigned PHASES     = 8;
    localparam int unsigned PHASE_LEN  = 135;
    localparam logic [kmeq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [kmeq_pkg::FRAME_W-1:0] ALL_UP = '1;
    // Bit 1 enables the left half, bit 0 the right half.
    localparam logic [1:0] HALF_PLAN [PHASES] = '{2'b11, 2'b00, 2'b10, 2'b01,
                                                  2'b11, 2'b10, 2'b11, 2'b01};

    class key_event_scoreboard;
        logic                        left_on;
        logic                        right_on;
        logic [COLS-1:0]             prev_rows [2][ROWS];
        logic [kmeq_pkg::CODE_W-1:0] ring [RING];
        int unsigned                 head;
        int unsigned                 tail;
        kmeq_pkg::out_word_t         pending [$];
        int                          errors;

        function new();
            release_keys();
            head = 0;
            tail = 0;
            left_on = 1'b0;
            right_on = 1'b0;
            errors = 0;
        endfunction

        function void release_keys();
            for (int h = 0; h < 2; h++) begin
                for (int r = 0; r < ROWS; r++) begin
                    prev_rows[h][r] = '1;
                end
            end
        endfunction

        function void note_word(kmeq_pkg::in_word_t w);
            kmeq_pkg::out_word_t         exp;
            logic                        shift_held;
            logic                        now_bit;
            logic [kmeq_pkg::CODE_W-1:0] code;
            exp = '0;
            case (w.op)
                kmeq_pkg::OP_SCAN: begin
                    shift_held = left_on && !w.scan_frame[SHIFT_BIT];
                    for (int h = 0; h < 2; h++) begin
                        if ((h == 0) ? left_on : right_on) begin
                            for (int r = 0; r < ROWS; r++) begin
                                for (int c = 0; c < COLS; c++) begin
                                    now_bit = w.scan_frame[h * ROWS * COLS + r * COLS + c];
                                    code = kmeq_pkg::KEYMAP[h][r][c];
                                    if (!now_bit && prev_rows[h][r][c] &&
                                        code != kmeq_pkg::CODE_NOP &&
                                        code != kmeq_pkg::CODE_SHIFT) begin
                                        if (shift_held && code >= kmeq_pkg::LOWER_A &&
                                            code <= kmeq_pkg::LOWER_Z) begin
                                            code = code - kmeq_pkg::CASE_OFFSET;
                                        end
                                        if ((head + 1) % RING != tail) begin
                                            ring[head] = code;
                                            head = (head + 1) % RING;
                                        end
                                    end
                                    prev_rows[h][r][c] = now_bit;
                                end
                            end
                        end
                    end
                end
                kmeq_pkg::OP_CLEAR: begin
                    release_keys();
                    head = 0;
                    tail = 0;
                end
                kmeq_pkg::OP_READ: begin
                    if (tail != head) begin
                        exp.key_code = ring[tail];
                        exp.key_valid = 1'b1;
                        tail = (tail + 1) % RING;
                    end
                end
                default: begin
                end
            endcase
            exp.keys_waiting = kmeq_pkg::WAIT_W'((head + RING - tail) % RING);
            pending.push_back(exp);
        endfunction

        function void check_word(kmeq_pkg::out_word_t got);
            kmeq_pkg::out_word_t exp;
            if (pending.size() == 0) begin
                $display("%0t: result word %h arrived with none expected", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.key_code !== exp.key_code) begin
                $display("%0t: key_code expected %h actual %h", $time, exp.key_code, got.key_code);
                errors++;
            end
            if (got.key_valid !== exp.key_valid) begin
                $display("%0t: key_valid expected %b actual %b", $time, exp.key_valid,
                         got.key_valid);
                errors++;
            end
            if (got.keys_waiting !== exp.keys_waiting) begin
                $display("%0t: keys_waiting expected %0d actual %0d", $time, exp.keys_waiting,
                         got.keys_waiting);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [kmeq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [kmeq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    kmeq_pkg::in_word_t              s_payload = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    kmeq_pkg::out_word_t             m_payload;

    key_event_scoreboard             sb;
    int                              send_idle_pct = 0;
    int                              recv_stall_pct = 0;
    logic                            long_hold_go = 1'b0;
    int                              hold_count = 0;
    logic [kmeq_pkg::FRAME_W-1:0]    held_keys = '1;

    key_matrix_event_queue_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (long_hold_go && hold_count < LONG_HOLD) begin
            hold_count <= hold_count + 1;
            m_ready <= 1'b0;
        end else if (recv_stall_pct == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_word(s_payload);
            end
            if (m_valid && m_ready) begin
                sb.check_word(m_payload);
            end
        end
    end

    function automatic kmeq_pkg::in_word_t make_word(logic [kmeq_pkg::OP_W-1:0] op,
                                                     logic [kmeq_pkg::FRAME_W-1:0] frame);
        kmeq_pkg::in_word_t w;
        w.op = op;
        w.scan_frame = frame;
        return w;
    endfunction

    function automatic logic [kmeq_pkg::FRAME_W-1:0] noise_frame();
        return kmeq_pkg::FRAME_W'({$urandom, $urandom});
    endfunction

    // Mostly typing: a few keys change between frames, with the shift key held now and then.
    function automatic logic [kmeq_pkg::FRAME_W-1:0] next_frame();
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(99);
        if (pick < 60) begin
            repeat ($urandom_range(3, 1)) begin
                idx = $urandom_range(kmeq_pkg::FRAME_W - 1);
                held_keys[idx] = ~held_keys[idx];
            end
            if ($urandom_range(3) == 0) begin
                held_keys[SHIFT_BIT] = ~held_keys[SHIFT_BIT];
            end
        end else if (pick < 75) begin
            held_keys = noise_frame();
        end else if (pick < 85) begin
            held_keys = ALL_UP;
        end else if (pick < 95) begin
            for (int i = 0; i < kmeq_pkg::FRAME_W; i++) begin
                held_keys[i] = ($urandom_range(99) >= 8);
            end
        end else begin
            held_keys = '0;
        end
        return held_keys;
    endfunction

    function automatic kmeq_pkg::in_word_t random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return make_word(kmeq_pkg::OP_SCAN, next_frame());
        end else if (pick < 92) begin
            return make_word(kmeq_pkg::OP_READ, noise_frame());
        end else if (pick < 96) begin
            return make_word(kmeq_pkg::OP_CLEAR, noise_frame());
        end
        return make_word(OP_UNUSED, noise_frame());
    endfunction

    task automatic send_word(input kmeq_pkg::in_word_t w);
        int gap;
        gap = 0;
        if (send_idle_pct != 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                gap++;
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_halves(input logic left, input logic right);
        cfg_we <= 1'b1;
        cfg_index <= kmeq_pkg::CFG_LEFT_PRESENT;
        cfg_wdata <= left;
        @(posedge aclk);
        cfg_index <= kmeq_pkg::CFG_RIGHT_PRESENT;
        cfg_wdata <= right;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.left_on = left;
        sb.right_on = right;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        logic [kmeq_pkg::FRAME_W-1:0] frame;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_halves(1'b1, 1'b1);

        send_word(make_word(kmeq_pkg::OP_SCAN, ALL_UP));
        send_word(make_word(kmeq_pkg::OP_SCAN, '0));
        repeat (RING) send_word(make_word(kmeq_pkg::OP_READ, ALL_UP));
        send_word(make_word(OP_UNUSED, noise_frame()));
        send_word(make_word(kmeq_pkg::OP_SCAN, ALL_UP));
        frame = ALL_UP;
        frame[2 * COLS] = 1'b0;
        send_word(make_word(kmeq_pkg::OP_SCAN, frame));
        send_word(make_word(kmeq_pkg::OP_CLEAR, '0));
        send_word(make_word(kmeq_pkg::OP_READ, '0));
        frame = ALL_UP;
        frame[SHIFT_BIT] = 1'b0;
        frame[SHIFT_BIT + 1] = 1'b0;
        send_word(make_word(kmeq_pkg::OP_SCAN, frame));
        send_word(make_word(kmeq_pkg::OP_READ, ALL_UP));
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            write_halves(HALF_PLAN[phase][1], HALF_PLAN[phase][0]);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 59;
                end
                default: begin
                    send_idle_pct = 36;
                    recv_stall_pct <= 36;
                end
            endcase
            if (phase == 4) begin
                long_hold_go <= 1'b1;
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_word(random_word());
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("key_matrix_event_queue_unit verification clean");
        end else begin
            $display("key_matrix_event_queue_unit verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("key_matrix_event_queue_unit verification failed");
        $finish;
    end

endmodule

### key_matrix_event_queue_unit.f
+incdir+rtl/core
rtl/core/kmeq_pkg.sv
rtl/core/kmeq_ram.sv
rtl/core/kmeq_scanner.sv
rtl/core/key_matrix_event_queue_unit.sv
rtl/core/kmeq_checker.sv
tb/sv/key_matrix_event_queue_unit_tb.sv
